### design/fixed_block_free_list_allocator_assert.svh
// Assertion macros used by the free list allocator top level.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBFLA_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("free list allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBFLA_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("free list allocator check failed");

`endif

### design/fbfla_pkg.sv
// Shared constants and types of the fixed block free list allocator.
package fbfla_pkg;

    localparam int CAPACITY       = 1024;
    localparam int IDX_W          = $clog2(CAPACITY);
    localparam int COUNT_W        = 11;
    localparam int SIZE_W         = 17;
    localparam int OFFSET_W       = 26;
    localparam int PROD_W         = IDX_W + SIZE_W;
    localparam int STATUS_W       = 2;
    localparam int MIN_BLOCK_SIZE = 8;
    localparam int COUNT_RESET    = 1024;
    localparam int SIZE_RESET     = 8;

    localparam int S_TDATA_W = ((IDX_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = IDX_W + OFFSET_W + COUNT_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    // Register selects, taken from the word address bit of paddr.
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

### design/fbfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fbfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/fixed_block_free_list_allocator.sv
// Top level of the fixed block free list allocator.
//
// Requests arrive on the s_axis channel: tuser carries the mode (allocate or
// free) and tdata the index of a block being returned. Each request gives one
// result on the m_axis channel: granted index, byte offset and blocks in use
// in tdata, the status code in tuser.
// A request is accepted in S_IDLE and its result is loaded into the output
// register in S_EXEC, once that register is free. The pace is set by
// the next-link memory: an allocate must read the head block's link from the
// synchronous RAM before the following request can see the new head.
// After reset a clearing pass chains every block to the next one in the
// link memory; no request is accepted during it, while the APB registers
// can be written and read at all times.
// A new request may be accepted while a result waits in the output register;
// if the receiver stalls, the following result is held back until the output
// register is free, and no further request is accepted meanwhile.
// block_count lies at address 0 and block_size at address 4.
module fixed_block_free_list_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbfla_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fbfla_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbfla_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    // Request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fbfla_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // free_index, zero padding
    input  logic                               s_axis_tuser,  // mode
    // Result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fbfla_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // granted_index, byte_offset,
                                                              // blocks_used, zero padding
    output logic [fbfla_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);

    import fbfla_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  block_count_reg;
    logic [SIZE_W-1:0]   block_size_reg;
    logic [IDX_W-1:0]    init_cnt_reg, init_cnt_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic                out_valid_reg, out_valid_next;

    logic                mode_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic [IDX_W-1:0]    out_index_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_used_reg;

    logic [IDX_W-1:0]    res_index;
    logic [OFFSET_W-1:0] res_offset;
    logic [STATUS_W-1:0] res_status;

    logic                cfg_write;
    logic                in_accept;
    logic                exec_fire;
    logic                alloc_ok;
    logic                free_ok;
    logic [COUNT_W-1:0]  eff_count;
    logic [SIZE_W-1:0]   eff_size;
    logic [PROD_W-1:0]   product;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_rdata;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= COUNT_W'(COUNT_RESET);
            block_size_reg  <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_BLOCK_COUNT: block_count_reg <= pwdata[COUNT_W-1:0];
                REG_BLOCK_SIZE:  block_size_reg  <= pwdata[SIZE_W-1:0];
                default:         block_size_reg  <= block_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_COUNT: prdata = APB_DATA_W'(block_count_reg);
            REG_BLOCK_SIZE:  prdata = APB_DATA_W'(block_size_reg);
            default:         prdata = '0;
        endcase
    end

    assign eff_count = (block_count_reg > COUNT_W'(CAPACITY)) ? COUNT_W'(CAPACITY)
                                                              : block_count_reg;
    assign eff_size  = (block_size_reg < SIZE_W'(MIN_BLOCK_SIZE)) ? SIZE_W'(MIN_BLOCK_SIZE)
                                                                  : block_size_reg;

    // ------------------------------------------------------------------
    // Next-link memory. The read port always follows the head, so the head's
    // link is ready in the cycle after a request is accepted.
    // ------------------------------------------------------------------
    fbfla_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    assign alloc_ok  = (mode_reg == MODE_ALLOC) && (used_reg < eff_count);
    assign free_ok   = (mode_reg == MODE_FREE) && (COUNT_W'(idx_reg) < eff_count);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_cnt_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = head_reg;
        init_cnt_next = init_cnt_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we        = 1'b1;
                ram_waddr     = init_cnt_reg;
                ram_wdata     = (init_cnt_reg == IDX_W'(CAPACITY - 1)) ? '0
                                                                        : init_cnt_reg + 1'b1;
                init_cnt_next = init_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                if (exec_fire && alloc_ok)
                begin
                    head_next = ram_rdata;
                    used_next = used_reg + 1'b1;
                end
                else if (exec_fire && free_ok)
                begin
                    // Push in front of the old head.
                    ram_we    = 1'b1;
                    head_next = idx_reg;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            head_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result datapath
    // ------------------------------------------------------------------
    assign product = PROD_W'(head_reg) * PROD_W'(eff_size);

    always_comb
    begin
        res_index  = '0;
        res_offset = '0;
        priority if (alloc_ok)
        begin
            res_status = STATUS_DONE;
            res_index  = head_reg;
            res_offset = product[OFFSET_W-1:0];
        end
        else if (mode_reg == MODE_ALLOC)
        begin
            res_status = STATUS_EXHAUSTED;
        end
        else if (free_ok)
        begin
            res_status = STATUS_DONE;
        end
        else
        begin
            res_status = STATUS_BAD_INDEX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= s_axis_tuser;
            idx_reg  <= s_axis_tdata[IDX_W-1:0];
        end
        if (exec_fire)
        begin
            out_index_reg  <= res_index;
            out_offset_reg <= res_offset;
            out_status_reg <= res_status;
            out_used_reg   <= used_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_used_reg, out_offset_reg, out_index_reg});
    assign m_axis_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "fixed_block_free_list_allocator_assert.svh"

    `FBFLA_ASSERT_SAME(a_no_accept_in_init, clk, rst_n, state_reg == S_INIT, !s_axis_tready)
    `FBFLA_ASSERT_SAME(a_used_bounded, clk, rst_n, 1'b1, used_reg <= COUNT_W'(CAPACITY))
    `FBFLA_ASSERT_SAME(a_result_from_exec, clk, rst_n, $rose(out_valid_reg),
                       $past(state_reg) == S_EXEC)
    `FBFLA_ASSERT_NEXT(a_refused_keeps_head, clk, rst_n,
                       exec_fire && !alloc_ok && !free_ok, $stable(head_reg) && $stable(used_reg))

endmodule

### tb/tb_fixed_block_free_list_allocator.sv
// Self-checking testbench for the fixed block free list allocator.
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator;
    import fbfla_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 244;
    localparam int PHASE_COUNT  = 8;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [IDX_W-1:0]    granted;
        logic [OFFSET_W-1:0] offset;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  used;
    } pool_result_t;

    // Tracks the free list as the block should hold it and queues the result
    // due for every accepted request.
    class pool_scoreboard;
        logic [IDX_W-1:0]   link_mem [CAPACITY];
        logic [IDX_W-1:0]   head;
        logic [COUNT_W-1:0] used;
        logic [COUNT_W-1:0] count_reg;
        logic [SIZE_W-1:0]  size_reg;
        pool_result_t       expected_results [$];
        logic [IDX_W-1:0]   last_granted;
        logic [STATUS_W-1:0] last_status;
        int                 errors;

        function new();
            for (int i = 0; i < CAPACITY; i++)
                link_mem[i] = IDX_W'((i + 1) % CAPACITY);
            head = '0;
            used = '0;
            count_reg = COUNT_W'(COUNT_RESET);
            size_reg = SIZE_W'(SIZE_RESET);
            errors = 0;
        endfunction

        function void note_request(logic mode, logic [IDX_W-1:0] idx);
            pool_result_t r;
            int pool_blocks;
            longint blk_bytes;
            pool_blocks = (count_reg > CAPACITY) ? CAPACITY : int'(count_reg);
            blk_bytes = (size_reg < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : longint'(size_reg);
            r.granted = '0;
            r.offset = '0;
            r.status = STATUS_DONE;
            if (mode == MODE_ALLOC) begin
                if (int'(used) >= pool_blocks) begin
                    r.status = STATUS_EXHAUSTED;
                end
                else begin
                    r.granted = head;
                    r.offset = OFFSET_W'(longint'(head) * blk_bytes);
                    head = link_mem[head];
                    used = used + 1'b1;
                end
            end
            else begin
                if (int'(idx) >= pool_blocks) begin
                    r.status = STATUS_BAD_INDEX;
                end
                else begin
                    link_mem[idx] = head;
                    head = idx;
                    if (used != 0)
                        used = used - 1'b1;
                end
            end
            r.used = used;
            last_granted = r.granted;
            last_status = r.status;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic [STATUS_W-1:0] status);
            pool_result_t want;
            logic [IDX_W-1:0]    got_granted;
            logic [OFFSET_W-1:0] got_offset;
            logic [COUNT_W-1:0]  got_used;
            got_granted = data[IDX_W-1:0];
            got_offset = data[IDX_W +: OFFSET_W];
            got_used = data[IDX_W+OFFSET_W +: COUNT_W];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, tdata %h", data));
            end
            else begin
                want = expected_results.pop_front();
                if (got_granted !== want.granted)
                    report_mismatch($sformatf("granted_index %0d, wanted %0d",
                                              got_granted, want.granted));
                if (got_offset !== want.offset)
                    report_mismatch($sformatf("byte_offset %0d, wanted %0d",
                                              got_offset, want.offset));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              status, want.status));
                if (got_used !== want.used)
                    report_mismatch($sformatf("blocks_used %0d, wanted %0d",
                                              got_used, want.used));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // free_index, zero padding
    logic                  s_axis_tuser;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // granted_index, byte_offset, blocks_used, padding
    logic [STATUS_W-1:0]   m_axis_tuser;   // status

    pool_scoreboard   pool_sb;
    logic [IDX_W-1:0] live_blocks [$];
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_cycles;
    int               cycle_count;

    int phase_block_count [PHASE_COUNT] = '{1024, 16, 1, 2047, 300, 4, 1000, 64};
    int phase_block_size  [PHASE_COUNT] = '{8, 100, 65536, 131071, 7, 0, 12345, 65535};
    int phase_send_idle   [PHASE_COUNT] = '{0, 58, 0, 32, 0, 58, 0, 32};
    int phase_recv_stall  [PHASE_COUNT] = '{0, 0, 58, 32, 0, 0, 58, 32};

    fixed_block_free_list_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Results are checked before the request of the same edge is noted; a
    // result can never belong to a request accepted at that very edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                pool_sb.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                pool_sb.note_request(s_axis_tuser, s_axis_tdata[IDX_W-1:0]);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transaction.
    task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= S_TDATA_W'(idx);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pool_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_BLOCK_COUNT)
            pool_sb.count_reg = value[COUNT_W-1:0];
        else
            pool_sb.size_reg = value[SIZE_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure_pool(input int blocks, input int bytes);
        wait_idle();
        apb_write(REG_BLOCK_COUNT, APB_DATA_W'(blocks));
        apb_write(REG_BLOCK_SIZE, APB_DATA_W'(bytes));
        @(negedge clk);
    endtask

    // Mostly allocate and return blocks that are really handed out; the rest
    // are frees of arbitrary indices (double frees, out of range).
    task automatic run_random_phase(input int items);
        int pick;
        int pos;
        logic [IDX_W-1:0] idx;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            if (pick < 48 || live_blocks.size() == 0) begin
                send_request(MODE_ALLOC, IDX_W'($urandom));
                if (pool_sb.last_status == STATUS_DONE)
                    live_blocks.push_back(pool_sb.last_granted);
            end
            else if (pick < 88) begin
                pos = $urandom_range(live_blocks.size() - 1);
                idx = live_blocks[pos];
                live_blocks.delete(pos);
                send_request(MODE_FREE, idx);
            end
            else begin
                send_request(MODE_FREE, IDX_W'($urandom_range(CAPACITY - 1)));
            end
        end
    endtask

    initial begin
        pool_sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_ALLOC;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset register values. The first
        // free arrives with nothing handed out.
        send_request(MODE_FREE, IDX_W'(CAPACITY - 1));
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_FREE, '0);

        // Count above the capacity, widest size: offset wraps at the top index.
        configure_pool(2047, 131071);
        send_request(MODE_FREE, IDX_W'(CAPACITY - 1));
        send_request(MODE_ALLOC, '0);

        // Two-block pool, size below the minimum block size.
        configure_pool(2, 0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, IDX_W'(2));
        send_request(MODE_FREE, '1);
        send_request(MODE_FREE, IDX_W'(1));
        send_request(MODE_FREE, IDX_W'(1));
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);

        // Empty pool: everything is refused.
        configure_pool(0, 65536);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, '0);

        configure_pool(1, 65536);
        send_request(MODE_FREE, '0);
        send_request(MODE_FREE, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, IDX_W'(1));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            configure_pool(phase_block_count[p], phase_block_size[p]);
            send_idle_pct = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            // One phase opens with a long receiver hold-off so the block backs up.
            if (p == 4)
                hold_cycles = 400;
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool_sb.expected_results.size() != 0)
            pool_sb.report_mismatch("results still outstanding at the end");
        if (pool_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
